// File: src/sfmf_pkg.sv
package sfmf_pkg;

	localparam int MAX_PATTERN_DEF   = 16;
	localparam int POSITION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 4;

	localparam int CFG_W   = 64;
	localparam int REG_IDX_W = 2;
	localparam int LEN_W   = 5;
	localparam int BYTE_W  = 8;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

	localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: src/sfmf_if.sv
interface sfmf_text_if;
	import sfmf_pkg::*;

	logic  valid;
	logic  ready;
	byte_t text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface sfmf_result_if #(
	parameter int POS_W = sfmf_pkg::POSITION_BITS_DEF
);
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] match_position;

	modport source (output valid, output found, output match_position, input ready);
	modport sink (input valid, input found, input match_position, output ready);
endinterface

// File: src/substring_first_match_finder.sv
// Substring first-match finder.
// text_in carries one text byte per item; a zero byte ends the string and
// restarts the search. result_out carries at most one item per string: on the
// byte that completes the first occurrence of the pattern (found=1, start
// offset, saturating), or on the terminating zero when there was none (found=0,
// position 0). An empty pattern reports position 0 on the first byte.
// The pattern is loaded through write_enable/reg_index/write_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Index 0 = bytes 0..7, 1 = bytes 8..15, 2 = length. One byte per cycle is
// taken while the result queue is not full; the window compare over all pattern
// bytes is done in the accept cycle, where any result is pushed into the queue.
// Results go through a small queue (QUEUE_DEPTH items). When result_out is
// stalled the front keeps taking bytes until that queue is full, then drops
// text_in.ready until an item is taken.
// Reset clears the pattern registers, the byte window, the position count and
// the queue.
module substring_first_match_finder #(
	parameter int MAX_PATTERN   = sfmf_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = sfmf_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH   = sfmf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_enable,
	input  logic [sfmf_pkg::REG_IDX_W-1:0] reg_index,
	input  logic [sfmf_pkg::CFG_W-1:0]     write_data,
	sfmf_text_if.sink                      text_in,
	sfmf_result_if.source                  result_out
);
	import sfmf_pkg::*;

	localparam int RW = POSITION_BITS + 1;

	logic                     take;
	logic                     push;
	logic                     push_found;
	logic [POSITION_BITS-1:0] push_pos;
	logic [RW-1:0]            head;
	logic                     empty;
	logic                     full;
	logic                     pop;

	assign text_in.ready = !full;
	assign take          = text_in.valid && !full;

	sfmf_front #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.take         (take),
		.text_byte    (text_in.text_byte),
		.push         (push),
		.push_found   (push_found),
		.push_pos     (push_pos)
	);

	sfmf_queue #(
		.WIDTH (RW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_found, push_pos}),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	assign pop                       = result_out.valid && result_out.ready;
	assign result_out.valid          = !empty;
	assign result_out.found          = head[RW-1];
	assign result_out.match_position = head[POSITION_BITS-1:0];

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.found) |-> (result_out.match_position == '0))
		else $error("no-match result with nonzero position");

	a_valid_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> $past(text_in.valid && text_in.ready))
		else $error("result appeared without an accepted byte");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full queue");

endmodule

// File: src/sfmf_front.sv
module sfmf_front #(
	parameter int MAX_PATTERN   = sfmf_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = sfmf_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               write_enable,
	input  logic [sfmf_pkg::REG_IDX_W-1:0]     reg_index,
	input  logic [sfmf_pkg::CFG_W-1:0]         write_data,
	input  logic                               take,
	input  sfmf_pkg::byte_t                    text_byte,
	output logic                               push,
	output logic                               push_found,
	output logic [POSITION_BITS-1:0]           push_pos
);
	import sfmf_pkg::*;

	localparam int PB    = POSITION_BITS;
	localparam int CLOG_M = $clog2(MAX_PATTERN + 1);
	localparam int CW    = (LEN_W > CLOG_M) ? LEN_W : CLOG_M;
	localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CMPW  = (PB > CW) ? PB : CW;
	localparam int WD    = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

	logic [CFG_W-1:0] pat_lo_q;
	logic [CFG_W-1:0] pat_hi_q;
	logic [LEN_W-1:0] plen_q;

	byte_t            win_q [WD];
	logic [PB-1:0]    cnt_q;
	logic             reported_q;

	byte_t            pat   [MAX_PATTERN];
	byte_t            seq   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] ok;
	logic [CW-1:0]    len;
	logic [CW-1:0]    len_m1;
	logic             is_nul;
	logic             sat;
	logic             eligible;
	logic             hit;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			plen_q   <= '0;
		end else if (write_enable) begin
			case (reg_index)
				REG_PATTERN_LOW:  pat_lo_q <= write_data;
				REG_PATTERN_HIGH: pat_hi_q <= write_data;
				REG_PATTERN_LEN:  plen_q   <= write_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
		if (i < 8) begin : g_lo
			assign pat[i] = pat_lo_q[8*i +: 8];
		end else if (i < 16) begin : g_hi
			assign pat[i] = pat_hi_q[8*(i-8) +: 8];
		end else begin : g_zero
			assign pat[i] = '0;
		end
	end

	assign len    = (CW'(plen_q) > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(plen_q);
	assign len_m1 = len - CW'(1);
	assign is_nul = (text_byte == NUL_BYTE);
	assign sat    = (cnt_q == '1);

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
		logic [CW-1:0] idx;
		if (k == 0) begin : g_cur
			assign seq[k] = text_byte;
		end else begin : g_win
			assign seq[k] = win_q[k-1];
		end
		assign idx   = len_m1 - CW'(k);
		assign ok[k] = (CW'(k) >= len) || (pat[idx[IW-1:0]] == seq[k]);
	end

	assign eligible = sat || (CMPW'(cnt_q) >= CMPW'(len_m1));
	assign hit      = eligible && (&ok);
	assign advance  = take && !is_nul && !reported_q && (len != '0);

	always_comb begin
		push       = 1'b0;
		push_found = 1'b0;
		push_pos   = '0;
		if (take && !reported_q) begin
			if (is_nul) begin
				push       = 1'b1;
				push_found = (len == '0);
			end else if (len == '0) begin
				push       = 1'b1;
				push_found = 1'b1;
			end else if (hit) begin
				push       = 1'b1;
				push_found = 1'b1;
				push_pos   = sat ? '1 : (cnt_q - PB'(len_m1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			reported_q <= 1'b0;
			for (int i = 0; i < WD; i++) begin
				win_q[i] <= '0;
			end
		end else if (take) begin
			if (is_nul) begin
				cnt_q      <= '0;
				reported_q <= 1'b0;
				for (int i = 0; i < WD; i++) begin
					win_q[i] <= '0;
				end
			end else if (!reported_q) begin
				if (len == '0) begin
					reported_q <= 1'b1;
				end else begin
					if (hit) begin
						reported_q <= 1'b1;
					end
					if (!sat) begin
						cnt_q <= cnt_q + PB'(1);
					end
				end
			end
			if (advance && (MAX_PATTERN > 1)) begin
				win_q[0] <= text_byte;
				for (int i = 1; i < WD; i++) begin
					win_q[i] <= win_q[i-1];
				end
			end
		end
	end

endmodule

// File: src/sfmf_queue.sv
module sfmf_queue #(
	parameter int WIDTH = 17,
	parameter int DEPTH = sfmf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

endmodule

// File: dv/tb_substring_first_match_finder.sv
`timescale 1ns / 1ps

module tb_substring_first_match_finder;
	import sfmf_pkg::*;

	localparam int MAX_PAT = MAX_PATTERN_DEF;
	localparam int POS_W = POSITION_BITS_DEF;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 34;
	localparam byte_t CH_A = 8'h61;
	localparam byte_t CH_B = 8'h62;
	localparam byte_t CH_C = 8'h63;
	localparam byte_t CH_X = 8'h78;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} search_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 write_enable;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     write_data;

	sfmf_text_if text_ch ();
	sfmf_result_if #(.POS_W(POS_W)) res_ch ();

	substring_first_match_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data),
		.text_in(text_ch.sink),
		.result_out(res_ch.source)
	);

	byte_t          text_pending[$];
	search_result_t results_due[$];
	int             mismatches = 0;
	int             src_gap_max = 0;
	int             snk_gap_max = 0;
	int             hold_req = 0;

	// search state as the block should hold it
	logic [63:0]        pat_lo_q;
	logic [63:0]        pat_hi_q;
	logic [LEN_W-1:0]   pat_len_q;
	byte_t              win_bytes[0:MAX_PAT-2];
	logic [POS_W-1:0]   offset_count;
	bit                 hit_given;

	// stimulus view of the loaded pattern
	byte_t cur_pat[0:15];
	int    cur_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("substring_first_match_finder test failed");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic byte_t pattern_at(input int i);
		if (i < 8)
			return pat_lo_q[8*i +: 8];
		if (i < 16)
			return pat_hi_q[8*(i-8) +: 8];
		return NUL_BYTE;
	endfunction

	task automatic clear_window();
		for (int k = 0; k < MAX_PAT - 1; k++)
			win_bytes[k] = NUL_BYTE;
		offset_count = '0;
		hit_given = 1'b0;
	endtask

	task automatic search_step(input byte_t b);
		int             len;
		bit             hit;
		bit             sat;
		logic [POS_W-1:0] pos;
		search_result_t r;
		len = (pat_len_q > MAX_PAT) ? MAX_PAT : int'(pat_len_q);
		if (b == NUL_BYTE) begin
			if (!hit_given) begin
				r.found = (len == 0);
				r.position = '0;
				results_due.push_back(r);
			end
			clear_window();
		end else if (!hit_given) begin
			if (len == 0) begin
				hit_given = 1'b1;
				r.found = 1'b1;
				r.position = '0;
				results_due.push_back(r);
			end else begin
				hit = 1'b0;
				pos = '0;
				sat = (offset_count == POS_MAX);
				if (sat || offset_count >= len - 1) begin
					hit = (pattern_at(len - 1) == b);
					for (int k = 1; k < len; k++)
						if (pattern_at(len - 1 - k) != win_bytes[k-1])
							hit = 1'b0;
					if (hit)
						pos = sat ? POS_MAX : offset_count - POS_W'(len - 1);
				end
				for (int k = MAX_PAT - 2; k > 0; k--)
					win_bytes[k] = win_bytes[k-1];
				win_bytes[0] = b;
				if (!sat)
					offset_count = offset_count + 1'b1;
				if (hit) begin
					hit_given = 1'b1;
					r.found = 1'b1;
					r.position = pos;
					results_due.push_back(r);
				end
			end
		end
	endtask

	logic text_fire;
	logic res_fire;

	always @(posedge clk or negedge arst_n) begin
		search_result_t r;
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			pat_len_q <= '0;
			clear_window();
			text_fire <= 1'b0;
			res_fire <= 1'b0;
		end else begin
			text_fire <= text_ch.valid && text_ch.ready;
			res_fire <= res_ch.valid && res_ch.ready;
			if (write_enable) begin
				case (reg_index)
					REG_PATTERN_LOW: pat_lo_q = write_data;
					REG_PATTERN_HIGH: pat_hi_q = write_data;
					REG_PATTERN_LEN: pat_len_q = write_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				if (results_due.size() == 0) begin
					log_mismatch($sformatf("unexpected result found=%0b pos=%0d",
						res_ch.found, res_ch.match_position));
				end else begin
					r = results_due.pop_front();
					if (res_ch.found !== r.found)
						log_mismatch($sformatf("found %0b, expected %0b",
							res_ch.found, r.found));
					if (res_ch.match_position !== r.position)
						log_mismatch($sformatf("match_position %0d, expected %0d",
							res_ch.match_position, r.position));
				end
			end
			if (text_ch.valid && text_ch.ready)
				search_step(text_ch.text_byte);
		end
	end

	// text sender
	int src_left = 0;
	always @(negedge clk) begin
		int unsigned g;
		if (arst_n && !(text_ch.valid && !text_fire)) begin
			if (src_left != 0) begin
				src_left <= src_left - 1;
				text_ch.valid <= 1'b0;
			end else if (text_pending.size() != 0) begin
				text_ch.valid <= 1'b1;
				text_ch.text_byte <= text_pending.pop_front();
				g = $urandom_range(0, src_gap_max);
				src_left <= g;
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else if (res_fire) begin
				w = $urandom_range(0, snk_gap_max);
				stall_left <= (w == 0) ? 0 : int'(w) - 1;
				res_ch.ready <= (w == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic drain();
		while (text_pending.size() != 0 || text_ch.valid || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= data;
		@(negedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic load_pattern();
		logic [63:0] lo;
		logic [63:0] hi;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = cur_pat[i];
			hi[8*i +: 8] = cur_pat[i+8];
		end
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LEN, CFG_W'(cur_len));
	endtask

	task automatic pick_pattern();
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 16; i++) begin
			case (mode)
				0: cur_pat[i] = 8'h00;
				1: cur_pat[i] = 8'hFF;
				2, 3, 4, 5: cur_pat[i] = CH_A + byte_t'($urandom_range(0, 2));
				default: cur_pat[i] = byte_t'($urandom_range(1, 255));
			endcase
		end
		if (mode == 5)
			cur_pat[$urandom_range(0, 15)] = NUL_BYTE;
		case ($urandom_range(0, 7))
			0: cur_len = 0;
			1: cur_len = 16;
			2: cur_len = $urandom_range(17, 31);
			default: cur_len = $urandom_range(1, 15);
		endcase
	endtask

	function automatic byte_t text_filler(input int plen);
		byte_t b;
		if (plen > 0 && $urandom_range(0, 1))
			b = cur_pat[$urandom_range(0, plen - 1)];
		else
			b = byte_t'($urandom_range(1, 255));
		if (b == NUL_BYTE)
			b = byte_t'($urandom_range(1, 255));
		return b;
	endfunction

	task automatic queue_string(output int n);
		int plen;
		int kind;
		int cnt;
		plen = (cur_len > MAX_PAT) ? MAX_PAT : cur_len;
		n = 0;
		cnt = $urandom_range(0, 12);
		repeat (cnt) begin
			text_pending.push_back(text_filler(plen));
			n++;
		end
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			for (int i = 0; i < plen; i++) begin
				text_pending.push_back(cur_pat[i]);
				n++;
			end
		end else if (kind < 8 && plen > 1) begin
			for (int i = 0; i < plen - 1; i++) begin
				text_pending.push_back(cur_pat[i]);
				n++;
			end
		end
		cnt = $urandom_range(0, 6);
		repeat (cnt) begin
			text_pending.push_back(text_filler(plen));
			n++;
		end
		text_pending.push_back(NUL_BYTE);
		n++;
	endtask

	initial begin
		int n;
		int phase_items;
		arst_n = 1'b0;
		write_enable = 1'b0;
		reg_index = '0;
		write_data = '0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pattern out of reset: NUL alone, then a byte and its NUL
		src_gap_max = 9;
		snk_gap_max = 9;
		text_pending.push_back(NUL_BYTE);
		text_pending.push_back(CH_A);
		text_pending.push_back(NUL_BYTE);
		drain();

		foreach (cur_pat[i])
			cur_pat[i] = NUL_BYTE;
		cur_pat[0] = CH_A;
		cur_pat[1] = CH_B;
		cur_pat[2] = CH_C;
		cur_len = 3;
		load_pattern();
		text_pending = '{CH_X, CH_A, CH_B, CH_C, NUL_BYTE, CH_A, CH_B, NUL_BYTE};
		drain();

		// all-ones pattern, length above the maximum
		foreach (cur_pat[i])
			cur_pat[i] = 8'hFF;
		cur_len = 31;
		load_pattern();
		repeat (16) text_pending.push_back(8'hFF);
		text_pending.push_back(NUL_BYTE);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			pick_pattern();
			load_pattern();
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				queue_string(n);
				phase_items += n;
			end
			drain();

			if (ph == RANDOM_PHASES / 2) begin
				// receiver stalls while short strings pile up results
				src_gap_max = 0;
				snk_gap_max = 0;
				cur_len = 0;
				load_pattern();
				hold_req++;
				repeat (24) begin
					text_pending.push_back(byte_t'($urandom_range(1, 255)));
					text_pending.push_back(NUL_BYTE);
				end
				drain();
			end
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("substring_first_match_finder test passed");
		end else begin
			$display("substring_first_match_finder test failed");
		end
		$finish;
	end

endmodule

// File: substring_first_match_finder.f
src/sfmf_pkg.sv
src/sfmf_if.sv
src/sfmf_front.sv
src/sfmf_queue.sv
src/substring_first_match_finder.sv
dv/tb_substring_first_match_finder.sv
